// File: rtl/ugb_pkg.sv
// ----------------------------------------------------------------------------
// ugb_pkg
// Shared types, widths and defaults of the uniform grid broad phase.
// ----------------------------------------------------------------------------
package ugb_pkg;

  // Fixed field widths of the item and result payloads.
  localparam int unsigned OpW     = 2;
  localparam int unsigned IdW     = 6;
  localparam int unsigned PixW    = 12;
  localparam int unsigned CoordW  = PixW + 1;  // sum of two pixel values
  localparam int unsigned SizeW   = 10;
  localparam int unsigned GridW   = 6;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 10;

  // Default sizes handed to the top level parameters.
  localparam int unsigned DefMaxColumns  = 32;
  localparam int unsigned DefMaxRows     = 32;
  localparam int unsigned DefSlotsPerCell = 8;
  localparam int unsigned DefMaxObjects  = 64;

  // Register reset values.
  localparam logic [SizeW-1:0] RstCellWidth  = SizeW'(32);
  localparam logic [SizeW-1:0] RstCellHeight = SizeW'(16);
  localparam logic [GridW-1:0] RstColumns    = GridW'(32);
  localparam logic [GridW-1:0] RstRows       = GridW'(32);

  typedef enum logic [OpW-1:0] {
    OP_CLEAR      = 2'd0,
    OP_INSERT     = 2'd1,
    OP_SET_ACTIVE = 2'd2,
    OP_QUERY      = 2'd3
  } ugb_op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CELL_WIDTH   = 2'd0,
    CFG_CELL_HEIGHT  = 2'd1,
    CFG_GRID_COLUMNS = 2'd2,
    CFG_GRID_ROWS    = 2'd3
  } ugb_cfg_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CELL_RD,
    ST_CELL_OP,
    ST_SLOT_RD,
    ST_SLOT_CHK,
    ST_EMIT,
    ST_RESP
  } ugb_state_e;

  // Write enables from the sequencer to the cell store.
  typedef struct packed {
    logic fill_we;
    logic ent_we;
  } ugb_mem_ctl_t;

endpackage

// File: rtl/ugb_if.sv
// ----------------------------------------------------------------------------
// ugb_in_if / ugb_out_if
// Valid/ready channels for operation items and result items.
// ----------------------------------------------------------------------------
interface ugb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [5:0]  object_id;
  logic [11:0] rect_left;
  logic [11:0] rect_top;
  logic [11:0] rect_width;
  logic [11:0] rect_height;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [11:0] radius;
  logic        active_flag;

  modport source (output valid, operation, object_id, rect_left, rect_top, rect_width,
                  rect_height, center_x, center_y, radius, active_flag, input ready);
  modport sink (input valid, operation, object_id, rect_left, rect_top, rect_width,
                rect_height, center_x, center_y, radius, active_flag, output ready);
endinterface

interface ugb_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] found_id;
  logic       found;
  logic       status;
  logic       last;

  modport source (output valid, found_id, found, status, last, input ready);
  modport sink (input valid, found_id, found, status, last, output ready);
endinterface

// File: rtl/ugb_div.sv
// ----------------------------------------------------------------------------
// ugb_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ugb_div
  import ugb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [CoordW-1:0] dividend_i,
  input  logic [SizeW-1:0]  divisor_i,
  output logic              done_o,
  output logic [CoordW-1:0] quotient_o
);

  localparam int unsigned CntW = $clog2(CoordW + 1);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [SizeW-1:0]  rem_q, rem_d;
  logic [CoordW-1:0] quo_q, quo_d;
  logic [SizeW-1:0]  div_q, div_d;
  logic [SizeW:0]    trial;
  logic [SizeW:0]    diff;

  // One shift and trial subtract per cycle.
  always_comb begin
    trial  = {rem_q, quo_q[CoordW-1]};
    diff   = trial - {1'b0, div_q};
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(CoordW);
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[SizeW-1:0];
        quo_d = {quo_q[CoordW-2:0], 1'b1};
      end else begin
        rem_d = trial[SizeW-1:0];
        quo_d = {quo_q[CoordW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/ugb_store.sv
// ----------------------------------------------------------------------------
// ugb_store
// Cell fill counts and cell slot entries, each a memory with registered read.
// ----------------------------------------------------------------------------
module ugb_store
  import ugb_pkg::*;
#(
  parameter int unsigned NumCells = DefMaxColumns * DefMaxRows,
  parameter int unsigned Slots    = DefSlotsPerCell
) (
  input  logic         clk_i,
  input  ugb_mem_ctl_t ctl_i,
  input  logic [((NumCells > 1) ? $clog2(NumCells) : 1)-1:0] fill_raddr_i,
  input  logic [((NumCells > 1) ? $clog2(NumCells) : 1)-1:0] fill_waddr_i,
  input  logic [$clog2(Slots + 1)-1:0] fill_wdata_i,
  output logic [$clog2(Slots + 1)-1:0] fill_rdata_o,
  input  logic [((NumCells * Slots > 1) ? $clog2(NumCells * Slots) : 1)-1:0] ent_raddr_i,
  input  logic [((NumCells * Slots > 1) ? $clog2(NumCells * Slots) : 1)-1:0] ent_waddr_i,
  input  logic [IdW-1:0] ent_wdata_i,
  output logic [IdW-1:0] ent_rdata_o
);

  localparam int unsigned FillW = $clog2(Slots + 1);

  logic [FillW-1:0] fill_mem [NumCells];
  logic [IdW-1:0]   ent_mem  [NumCells * Slots];

  // Fill counts: one write and one read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.fill_we) begin
      fill_mem[fill_waddr_i] <= fill_wdata_i;
    end
    fill_rdata_o <= fill_mem[fill_raddr_i];
  end

  // Slot entries: one write and one read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ent_we) begin
      ent_mem[ent_waddr_i] <= ent_wdata_i;
    end
    ent_rdata_o <= ent_mem[ent_raddr_i];
  end

endmodule

// File: rtl/uniform_grid_broadphase.sv
// ----------------------------------------------------------------------------
// uniform_grid_broadphase
// Uniform grid broad phase: clear, insert, set active and query sequencer.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake     Payload
// item_i     in   valid/ready   operation, object_id, rectangle, circle, flag
// result_o   out  valid/ready   found_id, found, status, last
// cfg        in   cfg_we_i      cfg_idx_i, cfg_data_i
//
// After reset the block sweeps all MAX_COLUMNS*MAX_ROWS fill counts to zero
// before it takes its first item; a clear item takes the same sweep.
// Insert and query run four divisions on the shared divider, then visit each
// covered cell in turn, and a query also reads each stored slot of a cell.
// A query then scans up to MAX_OBJECTS ids for results, one a cycle unless stalled.
// A stalled result register holds the sequencer; ready is high only when idle.
// ----------------------------------------------------------------------------
module uniform_grid_broadphase
  import ugb_pkg::*;
#(
  parameter int unsigned MAX_COLUMNS    = DefMaxColumns,
  parameter int unsigned MAX_ROWS       = DefMaxRows,
  parameter int unsigned SLOTS_PER_CELL = DefSlotsPerCell,
  parameter int unsigned MAX_OBJECTS    = DefMaxObjects
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ugb_in_if.sink             item_i,
  ugb_out_if.source          result_o
);

  localparam int unsigned NumCells = MAX_COLUMNS * MAX_ROWS;
  localparam int unsigned CellAw   = (NumCells > 1) ? $clog2(NumCells) : 1;
  localparam int unsigned EntAw    = (NumCells * SLOTS_PER_CELL > 1) ?
                                     $clog2(NumCells * SLOTS_PER_CELL) : 1;
  localparam int unsigned ColW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned RowW     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned IdxW     = (ColW > RowW) ? ColW : RowW;
  localparam int unsigned FillW    = $clog2(SLOTS_PER_CELL + 1);
  localparam int unsigned SlotW    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int unsigned ObjW     = $clog2(MAX_OBJECTS);
  localparam int unsigned CntW     = $clog2(MAX_OBJECTS + 1);
  localparam int unsigned NW       = 9;  // holds grid counts up to 511

  // Configuration registers.
  logic [SizeW-1:0] cell_w_q, cell_h_q;
  logic [GridW-1:0] cols_q, rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_w_q <= RstCellWidth;
      cell_h_q <= RstCellHeight;
      cols_q   <= RstColumns;
      rows_q   <= RstRows;
    end else if (cfg_we_i) begin
      unique case (ugb_cfg_e'(cfg_idx_i))
        CFG_CELL_WIDTH:   cell_w_q <= cfg_data_i;
        CFG_CELL_HEIGHT:  cell_h_q <= cfg_data_i;
        CFG_GRID_COLUMNS: cols_q   <= cfg_data_i[GridW-1:0];
        CFG_GRID_ROWS:    rows_q   <= cfg_data_i[GridW-1:0];
        default: ;
      endcase
    end
  end

  // Effective cell sizes and highest usable column and row.
  logic [SizeW-1:0] cell_w_eff, cell_h_eff;
  logic [NW-1:0]    n_cols, n_rows;
  logic [IdxW-1:0]  col_max, row_max;

  always_comb begin
    cell_w_eff = (cell_w_q == '0) ? SizeW'(1) : cell_w_q;
    cell_h_eff = (cell_h_q == '0) ? SizeW'(1) : cell_h_q;
    n_cols = (cols_q == '0) ? NW'(1) : NW'(cols_q);
    if (n_cols > NW'(MAX_COLUMNS)) n_cols = NW'(MAX_COLUMNS);
    n_rows = (rows_q == '0) ? NW'(1) : NW'(rows_q);
    if (n_rows > NW'(MAX_ROWS)) n_rows = NW'(MAX_ROWS);
    col_max = IdxW'(n_cols - NW'(1));
    row_max = IdxW'(n_rows - NW'(1));
  end

  // Sequencer registers.
  ugb_state_e          state_q, state_d;
  ugb_op_e             op_q, op_d;
  logic [IdW-1:0]      id_q, id_d;
  logic [CoordW-1:0]   coord_q [4];
  logic [CoordW-1:0]   coord_d [4];
  logic [IdxW-1:0]     bound_q [4];
  logic [IdxW-1:0]     bound_d [4];
  logic [1:0]          k_q, k_d;
  logic [RowW-1:0]     cur_r_q, cur_r_d;
  logic [ColW-1:0]     cur_c_q, cur_c_d;
  logic [FillW-1:0]    fill_q, fill_d;
  logic [SlotW-1:0]    slot_q, slot_d;
  logic                dropped_q, dropped_d;
  logic [MAX_OBJECTS-1:0] active_q, active_d;
  logic [MAX_OBJECTS-1:0] seen_q, seen_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [ObjW-1:0]     emit_q, emit_d;
  logic [CellAw-1:0]   sweep_q, sweep_d;

  // Result register.
  logic           out_valid_q, out_valid_d;
  logic [IdW-1:0] out_id_q, out_id_d;
  logic           out_found_q, out_found_d;
  logic           out_status_q, out_status_d;
  logic           out_last_q, out_last_d;

  // Divider and store connections.
  logic              div_start, div_done;
  logic [CoordW-1:0] div_quo;
  logic [IdxW-1:0]   quo_clamped, k_max;
  ugb_mem_ctl_t      mem_ctl;
  logic [CellAw-1:0] cell_addr, fill_waddr;
  logic [FillW-1:0]  fill_wdata, fill_rdata;
  logic [EntAw-1:0]  ent_raddr, ent_waddr;
  logic [IdW-1:0]    ent_rdata;

  ugb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (coord_q[k_q]),
    .divisor_i  (k_q[1] ? cell_h_eff : cell_w_eff),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  ugb_store #(
    .NumCells (NumCells),
    .Slots    (SLOTS_PER_CELL)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .fill_raddr_i (cell_addr),
    .fill_waddr_i (fill_waddr),
    .fill_wdata_i (fill_wdata),
    .fill_rdata_o (fill_rdata),
    .ent_raddr_i  (ent_raddr),
    .ent_waddr_i  (ent_waddr),
    .ent_wdata_i  (id_q),
    .ent_rdata_o  (ent_rdata)
  );

  // Cell and slot addresses of the current position.
  assign cell_addr = CellAw'(cur_r_q) * CellAw'(MAX_COLUMNS) + CellAw'(cur_c_q);
  assign ent_raddr = EntAw'(cell_addr) * EntAw'(SLOTS_PER_CELL) + EntAw'(slot_q);
  assign ent_waddr = EntAw'(cell_addr) * EntAw'(SLOTS_PER_CELL)
                     + EntAw'(fill_rdata[SlotW-1:0]);

  // Clamp a quotient to the grid extent of its axis.
  assign k_max       = k_q[1] ? row_max : col_max;
  assign quo_clamped = (div_quo > CoordW'(k_max)) ? k_max : IdxW'(div_quo);

  logic out_free;
  logic last_cell;
  logic item_ok;
  logic ent_ok;
  logic [CoordW-1:0] lo_x, lo_y;

  assign out_free  = !out_valid_q || result_o.ready;
  assign last_cell = (cur_c_q == ColW'(bound_q[1])) && (cur_r_q == RowW'(bound_q[3]));
  assign item_ok   = {1'b0, item_i.object_id} < (IdW + 1)'(MAX_OBJECTS);
  assign ent_ok    = {1'b0, ent_rdata} < (IdW + 1)'(MAX_OBJECTS);
  assign lo_x = (item_i.center_x >= item_i.radius) ?
                CoordW'(item_i.center_x - item_i.radius) : '0;
  assign lo_y = (item_i.center_y >= item_i.radius) ?
                CoordW'(item_i.center_y - item_i.radius) : '0;

  assign item_i.ready = (state_q == ST_IDLE);

  // Next state and datapath control.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    id_d      = id_q;
    coord_d   = coord_q;
    bound_d   = bound_q;
    k_d       = k_q;
    cur_r_d   = cur_r_q;
    cur_c_d   = cur_c_q;
    fill_d    = fill_q;
    slot_d    = slot_q;
    dropped_d = dropped_q;
    active_d  = active_q;
    seen_d    = seen_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    sweep_d   = sweep_q;
    div_start = 1'b0;
    mem_ctl   = '0;
    fill_waddr = cell_addr;
    fill_wdata = fill_rdata + FillW'(1);
    out_valid_d  = result_o.ready ? 1'b0 : out_valid_q;
    out_id_d     = out_id_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    unique case (state_q)
      // Clear fill counts one cell a cycle.
      ST_INIT, ST_CLEAR: begin
        mem_ctl.fill_we = 1'b1;
        fill_waddr      = sweep_q;
        fill_wdata      = '0;
        sweep_d         = sweep_q + CellAw'(1);
        if (sweep_q == CellAw'(NumCells - 1)) begin
          sweep_d = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end

      // Take an item and set up its operation.
      ST_IDLE: begin
        if (item_i.valid) begin
          op_d      = ugb_op_e'(item_i.operation);
          id_d      = item_i.object_id;
          dropped_d = 1'b0;
          k_d       = '0;
          unique case (ugb_op_e'(item_i.operation))
            OP_CLEAR: state_d = ST_CLEAR;
            OP_INSERT: begin
              coord_d[0] = CoordW'(item_i.rect_left);
              coord_d[1] = CoordW'(item_i.rect_left) + CoordW'(item_i.rect_width);
              coord_d[2] = CoordW'(item_i.rect_top);
              coord_d[3] = CoordW'(item_i.rect_top) + CoordW'(item_i.rect_height);
              if (item_ok) begin
                active_d[item_i.object_id[ObjW-1:0]] = 1'b1;
                state_d = ST_DIV_GO;
              end else begin
                state_d = ST_RESP;
              end
            end
            OP_SET_ACTIVE: begin
              if (item_ok) active_d[item_i.object_id[ObjW-1:0]] = item_i.active_flag;
              state_d = ST_RESP;
            end
            OP_QUERY: begin
              coord_d[0] = lo_x;
              coord_d[1] = CoordW'(item_i.center_x) + CoordW'(item_i.radius);
              coord_d[2] = lo_y;
              coord_d[3] = CoordW'(item_i.center_y) + CoordW'(item_i.radius);
              seen_d  = '0;
              cnt_d   = '0;
              emit_d  = '0;
              state_d = ST_DIV_GO;
            end
            default: ;
          endcase
        end
      end

      // Four divisions give the first and last column and row.
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end

      ST_DIV_WAIT: begin
        if (div_done) begin
          bound_d[k_q] = quo_clamped;
          k_d          = k_q + 2'd1;
          if (k_q == 2'd3) begin
            cur_c_d = ColW'(bound_q[0]);
            cur_r_d = RowW'(bound_q[2]);
            state_d = ST_CELL_RD;
          end else begin
            state_d = ST_DIV_GO;
          end
        end
      end

      // The fill count read is presented here and arrives next cycle.
      ST_CELL_RD: state_d = ST_CELL_OP;

      ST_CELL_OP: begin
        fill_d = fill_rdata;
        slot_d = '0;
        if (op_q == OP_INSERT) begin
          if (fill_rdata >= FillW'(SLOTS_PER_CELL)) begin
            dropped_d = 1'b1;
          end else begin
            mem_ctl.fill_we = 1'b1;
            mem_ctl.ent_we  = 1'b1;
          end
          state_d = ST_CELL_RD;
        end else if (fill_rdata != '0) begin
          state_d = ST_SLOT_RD;
        end else begin
          state_d = ST_CELL_RD;
        end
        if (state_d == ST_CELL_RD) begin
          if (last_cell) begin
            state_d = (op_q == OP_INSERT) ? ST_RESP : ST_EMIT;
          end else if (cur_c_q == ColW'(bound_q[1])) begin
            cur_c_d = ColW'(bound_q[0]);
            cur_r_d = cur_r_q + RowW'(1);
          end else begin
            cur_c_d = cur_c_q + ColW'(1);
          end
        end
      end

      // The slot entry read is presented here and arrives next cycle.
      ST_SLOT_RD: state_d = ST_SLOT_CHK;

      // Mark an active object seen, counting it once.
      ST_SLOT_CHK: begin
        if (ent_ok && active_q[ent_rdata[ObjW-1:0]] && !seen_q[ent_rdata[ObjW-1:0]]) begin
          seen_d[ent_rdata[ObjW-1:0]] = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end
        slot_d  = slot_q + SlotW'(1);
        state_d = ST_SLOT_RD;
        if (FillW'(slot_q) + FillW'(1) == fill_q) begin
          state_d = ST_CELL_RD;
          if (last_cell) begin
            state_d = ST_EMIT;
          end else if (cur_c_q == ColW'(bound_q[1])) begin
            cur_c_d = ColW'(bound_q[0]);
            cur_r_d = cur_r_q + RowW'(1);
          end else begin
            cur_c_d = cur_c_q + ColW'(1);
          end
        end
      end

      // Scan ids upward and emit every seen one.
      ST_EMIT: begin
        if (cnt_q == '0) begin
          state_d = ST_RESP;
        end else if (seen_q[emit_q]) begin
          if (out_free) begin
            out_valid_d  = 1'b1;
            out_id_d     = IdW'(emit_q);
            out_found_d  = 1'b1;
            out_status_d = 1'b0;
            out_last_d   = (cnt_q == CntW'(1));
            cnt_d        = cnt_q - CntW'(1);
            emit_d       = emit_q + ObjW'(1);
            if (cnt_q == CntW'(1)) state_d = ST_IDLE;
          end
        end else begin
          emit_d = emit_q + ObjW'(1);
        end
      end

      // Single result with nothing found.
      ST_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = '0;
          out_found_d  = 1'b0;
          out_status_d = dropped_q;
          out_last_d   = 1'b1;
          state_d      = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      active_q    <= '0;
      seen_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      active_q    <= active_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    id_q         <= id_d;
    coord_q      <= coord_d;
    bound_q      <= bound_d;
    k_q          <= k_d;
    cur_r_q      <= cur_r_d;
    cur_c_q      <= cur_c_d;
    fill_q       <= fill_d;
    slot_q       <= slot_d;
    dropped_q    <= dropped_d;
    emit_q       <= emit_d;
    out_id_q     <= out_id_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_last_q   <= out_last_d;
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.found_id = out_id_q;
  assign result_o.found    = out_found_q;
  assign result_o.status   = out_status_q;
  assign result_o.last     = out_last_q;

endmodule
